FILE: src/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// Miller-Rabin prime test package
// Shared types, widths, the fixed base table and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int VAL_W   = 31;
    localparam int CNT_W   = 5;
    localparam int BIDX_W  = 4;
    localparam int BASE_W  = 6;
    localparam int TAB_LEN = 12;

    // Operand selection for the shared modular multiplier.
    typedef enum logic [1:0] {
        OP_TRIAL  = 2'd0,
        OP_SQUARE = 2'd1,
        OP_BASE   = 2'd2
    } mul_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    mul_go;
        mul_op_t mul_op;
        logic    set_flag;
        logic    flag_val;
        logic    bidx_clr;
        logic    bidx_inc;
        logic    split_init;
        logic    d_shift;
        logic    exp_init;
        logic    x_from_mul;
        logic    ecnt_dec;
        logic    sq_init;
        logic    sq_inc;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_lt2;
        logic n_eq_base;
        logic mul_done;
        logic mul_zero;
        logic mul_one;
        logic x_trivial;
        logic x_one;
        logic base_last;
        logic d_odd;
        logic ebit;
        logic ecnt_zero;
        logic sq_end;
    } dp_stat_t;

    // Fixed base table: the first twelve primes.
    function automatic logic [BASE_W-1:0] base_of(input logic [BIDX_W-1:0] idx);
        logic [BASE_W-1:0] b;
        case (idx)
            4'd0:    b = 6'd2;
            4'd1:    b = 6'd3;
            4'd2:    b = 6'd5;
            4'd3:    b = 6'd7;
            4'd4:    b = 6'd11;
            4'd5:    b = 6'd13;
            4'd6:    b = 6'd17;
            4'd7:    b = 6'd19;
            4'd8:    b = 6'd23;
            4'd9:    b = 6'd29;
            4'd10:   b = 6'd31;
            4'd11:   b = 6'd37;
            default: b = 6'd37;
        endcase
        return b;
    endfunction

endpackage

FILE: src/mrpt_modmul.sv
// ----------------------------------------------------------------------------
// Iterative modular multiplier
// Computes a*b mod m, one bit of b per cycle, most significant bit first,
// by interleaved doubling and conditional addition. Requires a < m.
// ----------------------------------------------------------------------------
module mrpt_modmul
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [mrpt_pkg::VAL_W-1:0]  a,
    input  logic [mrpt_pkg::VAL_W-1:0]  b,
    input  logic [mrpt_pkg::VAL_W-1:0]  m,
    output logic                        done,
    output logic [mrpt_pkg::VAL_W-1:0]  result
);

    logic [mrpt_pkg::VAL_W-1:0] a_reg;
    logic [mrpt_pkg::VAL_W-1:0] b_reg;
    logic [mrpt_pkg::VAL_W-1:0] m_reg;
    logic [mrpt_pkg::VAL_W-1:0] r_reg;
    logic [mrpt_pkg::VAL_W-1:0] r_next;
    logic [mrpt_pkg::CNT_W-1:0] cnt_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic [mrpt_pkg::VAL_W:0]   dbl;
    logic [mrpt_pkg::VAL_W:0]   dbl_red;
    logic [mrpt_pkg::VAL_W:0]   sum;
    logic [mrpt_pkg::VAL_W:0]   m_ext;

    // One step: double the residue, reduce, add a if the bit is set, reduce.
    always_comb
    begin
        m_ext   = {1'b0, m_reg};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum     = dbl_red + (b_reg[mrpt_pkg::VAL_W-1] ? {1'b0, a_reg} : '0);
        r_next  = (sum >= m_ext) ? mrpt_pkg::VAL_W'(sum - m_ext)
                                 : sum[mrpt_pkg::VAL_W-1:0];
    end

    // Control: step once per bit of b, then pulse done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go && !run_reg)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == mrpt_pkg::CNT_W'(mrpt_pkg::VAL_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and the running residue.
    always_ff @(posedge clk)
    begin
        if (go && !run_reg)
        begin
            a_reg <= a;
            b_reg <= b;
            m_reg <= m;
            r_reg <= '0;
        end
        else if (run_reg)
        begin
            r_reg <= r_next;
            b_reg <= {b_reg[mrpt_pkg::VAL_W-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

FILE: src/mrpt_datapath.sv
// ----------------------------------------------------------------------------
// Miller-Rabin datapath
// Holds the candidate, the odd part and power of two of candidate-1, the
// working residue and loop counters, and the shared modular multiplier.
// ----------------------------------------------------------------------------
module mrpt_datapath
#(
    parameter int NUM_BASES = 12
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mrpt_pkg::VAL_W-1:0]  candidate,
    input  mrpt_pkg::dp_cmd_t           cmd,
    output mrpt_pkg::dp_stat_t          stat,
    output logic                        prime_flag
);

    localparam int EFF_BASES = (NUM_BASES > mrpt_pkg::TAB_LEN) ? mrpt_pkg::TAB_LEN
                             : ((NUM_BASES < 1) ? 1 : NUM_BASES);

    logic [mrpt_pkg::VAL_W-1:0]  n_reg;
    logic [mrpt_pkg::VAL_W-1:0]  d_reg;
    logic [mrpt_pkg::VAL_W-1:0]  x_reg;
    logic [mrpt_pkg::CNT_W-1:0]  s_reg;
    logic [mrpt_pkg::CNT_W-1:0]  j_reg;
    logic [mrpt_pkg::CNT_W-1:0]  ecnt_reg;
    logic [mrpt_pkg::BIDX_W-1:0] bidx_reg;
    logic                        flag_reg;
    logic [mrpt_pkg::VAL_W-1:0]  base;
    logic [mrpt_pkg::VAL_W-1:0]  n_m1;
    logic [mrpt_pkg::VAL_W-1:0]  mul_a;
    logic [mrpt_pkg::VAL_W-1:0]  mul_b;
    logic [mrpt_pkg::VAL_W-1:0]  mul_m;
    logic [mrpt_pkg::VAL_W-1:0]  mul_res;
    logic                        mul_done;

    assign base = mrpt_pkg::VAL_W'(mrpt_pkg::base_of(bidx_reg));
    assign n_m1 = n_reg - 1'b1;

    // Operand selection for the multiplier.
    always_comb
    begin
        case (cmd.mul_op)
            mrpt_pkg::OP_TRIAL:
            begin
                mul_a = mrpt_pkg::VAL_W'(1);
                mul_b = n_reg;
                mul_m = base;
            end
            mrpt_pkg::OP_BASE:
            begin
                mul_a = x_reg;
                mul_b = base;
                mul_m = n_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
                mul_m = n_reg;
            end
        endcase
    end

    mrpt_modmul u_modmul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (cmd.mul_go),
        .a      (mul_a),
        .b      (mul_b),
        .m      (mul_m),
        .done   (mul_done),
        .result (mul_res)
    );

    // Result flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else if (cmd.set_flag)
        begin
            flag_reg <= cmd.flag_val;
        end
    end

    // Working registers under controller command.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= candidate;
        end
        if (cmd.bidx_clr)
        begin
            bidx_reg <= '0;
        end
        else if (cmd.bidx_inc)
        begin
            bidx_reg <= bidx_reg + 1'b1;
        end
        if (cmd.split_init)
        begin
            d_reg <= n_m1;
            s_reg <= '0;
        end
        else if (cmd.d_shift)
        begin
            d_reg <= {1'b0, d_reg[mrpt_pkg::VAL_W-1:1]};
            s_reg <= s_reg + 1'b1;
        end
        if (cmd.exp_init)
        begin
            x_reg    <= mrpt_pkg::VAL_W'(1);
            ecnt_reg <= mrpt_pkg::CNT_W'(mrpt_pkg::VAL_W - 1);
        end
        else
        begin
            if (cmd.x_from_mul)
            begin
                x_reg <= mul_res;
            end
            if (cmd.ecnt_dec)
            begin
                ecnt_reg <= ecnt_reg - 1'b1;
            end
        end
        if (cmd.sq_init)
        begin
            j_reg <= '0;
        end
        else if (cmd.sq_inc)
        begin
            j_reg <= j_reg + 1'b1;
        end
    end

    // Status back to the controller.
    always_comb
    begin
        stat.n_lt2     = (n_reg < mrpt_pkg::VAL_W'(2));
        stat.n_eq_base = (n_reg == base);
        stat.mul_done  = mul_done;
        stat.mul_zero  = (mul_res == '0);
        stat.mul_one   = (mul_res == mrpt_pkg::VAL_W'(1));
        stat.x_one     = (x_reg == mrpt_pkg::VAL_W'(1));
        stat.x_trivial = (x_reg == mrpt_pkg::VAL_W'(1)) || (x_reg == n_m1);
        stat.base_last = (bidx_reg == mrpt_pkg::BIDX_W'(EFF_BASES - 1));
        stat.d_odd     = d_reg[0];
        stat.ebit      = d_reg[ecnt_reg];
        stat.ecnt_zero = (ecnt_reg == '0);
        stat.sq_end    = (j_reg == s_reg);
    end

    assign prime_flag = flag_reg;

endmodule

FILE: src/mrpt_ctrl.sv
// ----------------------------------------------------------------------------
// Miller-Rabin controller
// Sequences trial division, the split of candidate-1, square-and-multiply
// exponentiation and the squaring chain for every base.
// ----------------------------------------------------------------------------
module mrpt_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mrpt_pkg::dp_stat_t  stat,
    output mrpt_pkg::dp_cmd_t   cmd,
    output logic                busy,
    output logic                done
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'h0001,
        S_CHECK_N   = 15'h0002,
        S_TRIAL_CHK = 15'h0004,
        S_TRIAL_W   = 15'h0008,
        S_SPLIT     = 15'h0010,
        S_EXP_SQ    = 15'h0020,
        S_EXP_SQ_W  = 15'h0040,
        S_EXP_BIT   = 15'h0080,
        S_EXP_MUL   = 15'h0100,
        S_EXP_MUL_W = 15'h0200,
        S_EXP_NEXT  = 15'h0400,
        S_SQ_CHK    = 15'h0800,
        S_SQ_W      = 15'h1000,
        S_BASE_NEXT = 15'h2000,
        S_DONE      = 15'h4000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = mrpt_pkg::OP_SQUARE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    cmd.bidx_clr = 1'b1;
                    state_next   = S_CHECK_N;
                end
            end
            S_CHECK_N:
            begin
                if (stat.n_lt2)
                begin
                    cmd.set_flag = 1'b1;
                    cmd.flag_val = 1'b0;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_TRIAL_CHK;
                end
            end
            S_TRIAL_CHK:
            begin
                cmd.mul_op = mrpt_pkg::OP_TRIAL;
                if (stat.n_eq_base)
                begin
                    cmd.set_flag = 1'b1;
                    cmd.flag_val = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.mul_go = 1'b1;
                    state_next = S_TRIAL_W;
                end
            end
            S_TRIAL_W:
            begin
                cmd.mul_op = mrpt_pkg::OP_TRIAL;
                if (stat.mul_done)
                begin
                    if (stat.mul_zero)
                    begin
                        cmd.set_flag = 1'b1;
                        cmd.flag_val = 1'b0;
                        state_next   = S_DONE;
                    end
                    else if (stat.base_last)
                    begin
                        cmd.bidx_clr   = 1'b1;
                        cmd.split_init = 1'b1;
                        state_next     = S_SPLIT;
                    end
                    else
                    begin
                        cmd.bidx_inc = 1'b1;
                        state_next   = S_TRIAL_CHK;
                    end
                end
            end
            S_SPLIT:
            begin
                if (stat.d_odd)
                begin
                    cmd.exp_init = 1'b1;
                    state_next   = S_EXP_SQ;
                end
                else
                begin
                    cmd.d_shift = 1'b1;
                end
            end
            S_EXP_SQ:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_EXP_SQ_W;
            end
            S_EXP_SQ_W:
            begin
                if (stat.mul_done)
                begin
                    cmd.x_from_mul = 1'b1;
                    state_next     = S_EXP_BIT;
                end
            end
            S_EXP_BIT:
            begin
                state_next = stat.ebit ? S_EXP_MUL : S_EXP_NEXT;
            end
            S_EXP_MUL:
            begin
                cmd.mul_op = mrpt_pkg::OP_BASE;
                cmd.mul_go = 1'b1;
                state_next = S_EXP_MUL_W;
            end
            S_EXP_MUL_W:
            begin
                cmd.mul_op = mrpt_pkg::OP_BASE;
                if (stat.mul_done)
                begin
                    cmd.x_from_mul = 1'b1;
                    state_next     = S_EXP_NEXT;
                end
            end
            S_EXP_NEXT:
            begin
                if (stat.ecnt_zero)
                begin
                    cmd.sq_init = 1'b1;
                    state_next  = S_SQ_CHK;
                end
                else
                begin
                    cmd.ecnt_dec = 1'b1;
                    state_next   = S_EXP_SQ;
                end
            end
            S_SQ_CHK:
            begin
                if (stat.sq_end)
                begin
                    if (stat.x_one)
                    begin
                        state_next = S_BASE_NEXT;
                    end
                    else
                    begin
                        cmd.set_flag = 1'b1;
                        cmd.flag_val = 1'b0;
                        state_next   = S_DONE;
                    end
                end
                else
                begin
                    cmd.mul_go = 1'b1;
                    state_next = S_SQ_W;
                end
            end
            S_SQ_W:
            begin
                if (stat.mul_done)
                begin
                    if (stat.mul_one && !stat.x_trivial)
                    begin
                        // A nontrivial square root of one proves compositeness.
                        cmd.set_flag = 1'b1;
                        cmd.flag_val = 1'b0;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.x_from_mul = 1'b1;
                        cmd.sq_inc     = 1'b1;
                        state_next     = S_SQ_CHK;
                    end
                end
            end
            S_BASE_NEXT:
            begin
                if (stat.base_last)
                begin
                    cmd.set_flag = 1'b1;
                    cmd.flag_val = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.bidx_inc = 1'b1;
                    cmd.exp_init = 1'b1;
                    state_next   = S_EXP_SQ;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    // The result strobe lasts a single cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // An accepted item makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item did not start processing");

    // The multiplier only finishes while the controller waits for it.
    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.mul_done |-> (state_reg == S_TRIAL_W || state_reg == S_EXP_SQ_W ||
                           state_reg == S_EXP_MUL_W || state_reg == S_SQ_W))
        else $error("multiplier finished outside a wait state");

endmodule

FILE: src/miller_rabin_prime_test_unit.sv
// Each modular multiplication runs on the shared bit-serial multiplier;
// a full test needs up to 12 trial reductions plus, per base, 31
// squarings, one multiply per set bit of the odd part and up to 30 squarings.
// One candidate at a time; start is taken only while busy is low.
// Reset clears the controller to idle; results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// Miller-Rabin prime test unit
// Deterministic primality test of a 31-bit number against fixed prime bases.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_unit
#(
    parameter int NUM_BASES = 12
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mrpt_pkg::VAL_W-1:0]  candidate,
    output logic                        busy,
    output logic                        done,
    output logic                        prime_flag
);

    mrpt_pkg::dp_cmd_t  cmd;
    mrpt_pkg::dp_stat_t stat;

    // Sequencing.
    mrpt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Arithmetic and working state.
    mrpt_datapath #(
        .NUM_BASES (NUM_BASES)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .candidate  (candidate),
        .cmd        (cmd),
        .stat       (stat),
        .prime_flag (prime_flag)
    );

endmodule
